// File: rtl/fpsp_pkg.sv
`timescale 1ns / 1ps
package fpsp_pkg;

    // Most frame widths one plan may produce
    localparam logic [6:0] MAX_STEPS = 7'd64;

    // Microseconds per millisecond, and its scaled reciprocal for the split unit
    localparam logic [9:0]  US_PER_MS   = 10'd1000;
    localparam logic [21:0] RECIP_K     = 22'd2147484;   // ceil(2^31 / 1000)

    // Configuration register indexes
    localparam logic [2:0] CFG_STEP_MS      = 3'd0;
    localparam logic [2:0] CFG_FRAMETIME_MS = 3'd1;
    localparam logic [2:0] CFG_MAX_DRIFT_MS = 3'd2;
    localparam logic [2:0] CFG_WORK_US      = 3'd3;
    localparam logic [2:0] CFG_SLEEP_US     = 3'd4;
    localparam logic [2:0] CFG_STEP_LIMIT   = 3'd5;

    // Configuration reset values
    localparam logic [9:0]  RST_STEP_MS      = 10'd8;
    localparam logic [9:0]  RST_FRAMETIME_MS = 10'd0;
    localparam logic [15:0] RST_MAX_DRIFT_MS = 16'd1000;
    localparam logic [19:0] RST_WORK_US      = 20'd0;
    localparam logic [19:0] RST_SLEEP_US     = 20'd1000;
    localparam logic [6:0]  RST_STEP_LIMIT   = 7'd64;

    typedef struct packed {
        logic [9:0]  step_ms;
        logic [9:0]  frametime_ms;
        logic [15:0] max_drift_ms;
        logic [19:0] work_us;
        logic [19:0] sleep_us;
        logic [6:0]  step_limit;
    } t_cfg;

    // Datapath operations issued by the controller
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;   // take target, reseed if needed
    localparam t_op OP_SPL1  = 4'd2;   // split unit: reciprocal product
    localparam t_op OP_SPL2  = 4'd3;   // split unit: quotient and remainder
    localparam t_op OP_WSAV  = 4'd4;   // keep split of work time
    localparam t_op OP_CHECK = 4'd5;   // evaluate loop condition
    localparam t_op OP_EMIT  = 4'd6;   // load output register with a frame
    localparam t_op OP_EMPTY = 4'd7;   // load output register with empty result
    localparam t_op OP_WORK  = 4'd8;   // add work time to clock
    localparam t_op OP_PULL  = 4'd9;   // backward-clock guard
    localparam t_op OP_DIFF  = 4'd10;  // distance to the required frame
    localparam t_op OP_DIVGO = 4'd11;  // start remainder unit
    localparam t_op OP_ADDX  = 4'd12;  // round sleep total up to whole turns
    localparam t_op OP_SADD  = 4'd13;  // add sleep total to clock
    localparam t_op OP_FIN   = 4'd14;  // credit frame width

    typedef struct packed {
        logic cont;
        logic count_zero;
        logic need;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

// File: rtl/fpsp_div.sv
`timescale 1ns / 1ps
module fpsp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_busy,
    output logic [19:0] o_rem
);

    // Restoring remainder, four bits per cycle
    localparam logic [2:0] LAST_ITER = 3'd4;

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [19:0] r_num;
    logic [19:0] r_den;
    logic [19:0] r_rem;

    logic [19:0] n_num;
    logic [19:0] n_rem;
    logic [20:0] w_sh;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        w_sh  = '0;
        for (int j = 0; j < 4; j++) begin
            w_sh  = {n_rem, n_num[19]};
            n_num = {n_num[18:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh[19:0] - r_den;
            end else begin
                n_rem = w_sh[19:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == LAST_ITER) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// File: rtl/fpsp_dp.sv
`timescale 1ns / 1ps
module fpsp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpsp_pkg::t_op     i_op,
    input  fpsp_pkg::t_cfg    i_cfg,
    input  logic [30:0]       i_target_ms,
    input  logic              i_out_ready,
    output fpsp_pkg::t_status o_status,
    output logic              o_out_valid,
    output logic [15:0]       o_width_ms,
    output logic [31:0]       o_first_start_ms,
    output logic              o_no_steps,
    output logic              o_starved,
    output logic              o_last_of_run
);

    // Clock kept as whole ms (floor) plus sub-ms remainder in 0..999
    logic signed [32:0] r_m;
    logic [9:0]         r_r;
    logic signed [32:0] r_last;
    logic               r_started;
    logic [30:0]        r_target;
    logic [6:0]         r_count;
    logic [31:0]        r_first;
    logic [20:0]        r_x;
    logic [42:0]        r_prod;
    logic [11:0]        r_sq;
    logic [9:0]         r_sr;
    logic [11:0]        r_wq;
    logic [9:0]         r_wr;
    logic [19:0]        r_diff;
    logic               r_need;
    logic               r_cont;
    logic               r_stv;
    logic [15:0]        r_width;

    logic               r_ov;
    logic [15:0]        r_o_width;
    logic [31:0]        r_o_first;
    logic               r_o_nosteps;
    logic               r_o_starved;
    logic               r_o_last;

    logic [9:0]         w_step;
    logic [19:0]        w_sleep;
    logic [6:0]         w_limit;
    logic signed [32:0] w_f;
    logic signed [32:0] w_tgt;
    logic               w_below;

    logic signed [33:0] w_dist;
    logic [33:0]        w_dist_abs;
    logic               w_reseed;
    logic [9:0]         w_off;
    logic signed [32:0] w_behind;

    logic [11:0]        w_q;
    logic [21:0]        w_qk;
    logic [21:0]        w_rem_raw;
    logic               w_corr;
    logic [21:0]        w_rem_fix;

    logic [11:0]        w_add_q;
    logic [9:0]         w_add_r;
    logic [10:0]        w_rs;
    logic               w_carry;
    logic [10:0]        w_rs_fix;
    logic signed [32:0] w_m_sum;

    logic signed [32:0] w_last_pull;
    logic signed [33:0] w_gap;
    logic               w_gap_lt;
    logic signed [33:0] w_k;
    logic               w_kpos;
    logic signed [34:0] w_dk;
    logic signed [34:0] w_e;
    logic               w_e_ok;
    logic [20:0]        w_emul;
    logic signed [22:0] w_diffv;
    logic               w_need;
    logic [15:0]        w_wsat;

    logic               w_div_busy;
    logic [19:0]        w_div_rem;
    logic [19:0]        w_pad;

    assign w_step  = (i_cfg.step_ms == 10'd0) ? 10'd1 : i_cfg.step_ms;
    assign w_sleep = (i_cfg.sleep_us == 20'd0) ? 20'd1 : i_cfg.sleep_us;
    assign w_limit = (i_cfg.step_limit > fpsp_pkg::MAX_STEPS) ? fpsp_pkg::MAX_STEPS
                                                               : i_cfg.step_limit;

    // Whole ms of the clock, truncated toward zero
    assign w_f     = r_m + $signed({32'd0, (r_m[32] && (r_r != 10'd0))});
    assign w_tgt   = $signed({2'b00, r_target});
    assign w_below = (w_f < w_tgt);

    // Reseed decision on a new target
    assign w_dist     = $signed({3'b000, i_target_ms}) - $signed({r_last[32], r_last});
    assign w_dist_abs = w_dist[33] ? (34'd0 - w_dist) : w_dist;
    assign w_reseed   = !r_started || (w_dist_abs > {18'd0, i_cfg.max_drift_ms});
    assign w_off      = (i_cfg.frametime_ms != 10'd0) ? i_cfg.frametime_ms : w_step;
    assign w_behind   = $signed({2'b00, i_target_ms}) - $signed({23'd0, w_off});

    // Split of r_x into ms and us
    assign w_q       = r_prod[42:31];
    assign w_qk      = {10'd0, w_q} * {12'd0, fpsp_pkg::US_PER_MS};
    assign w_rem_raw = {1'b0, r_x} - w_qk;
    assign w_corr    = (w_rem_raw >= {12'd0, fpsp_pkg::US_PER_MS});
    assign w_rem_fix = w_corr ? (w_rem_raw - {12'd0, fpsp_pkg::US_PER_MS}) : w_rem_raw;

    // Clock adder
    assign w_add_q  = (i_op == fpsp_pkg::OP_WORK) ? r_wq : r_sq;
    assign w_add_r  = (i_op == fpsp_pkg::OP_WORK) ? r_wr : r_sr;
    assign w_rs     = {1'b0, r_r} + {1'b0, w_add_r};
    assign w_carry  = (w_rs >= {1'b0, fpsp_pkg::US_PER_MS});
    assign w_rs_fix = w_carry ? (w_rs - {1'b0, fpsp_pkg::US_PER_MS}) : w_rs;
    assign w_m_sum  = r_m + $signed({21'd0, w_add_q}) + $signed({32'd0, w_carry});

    assign w_last_pull = (r_last > w_f) ? w_f : r_last;

    // Distance from the clock to the required frame, in us
    assign w_gap    = $signed({w_f[32], w_f}) - $signed({r_last[32], r_last});
    assign w_gap_lt = (w_gap < $signed({24'd0, w_step}));
    assign w_k      = $signed({r_last[32], r_last}) + $signed({24'd0, w_step});
    assign w_kpos   = (w_k > 34'sd0);
    assign w_dk     = $signed({w_k[33], w_k}) - $signed({r_m[32], r_m[32], r_m});
    assign w_e      = w_kpos ? w_dk : (w_dk - 35'sd1);
    assign w_e_ok   = (w_e[34:11] == 24'd0);
    assign w_emul   = {10'd0, w_e[10:0]} * {11'd0, fpsp_pkg::US_PER_MS};
    assign w_diffv  = $signed({2'b00, w_emul}) + $signed({22'd0, !w_kpos})
                      - $signed({13'd0, r_r});
    assign w_need   = w_gap_lt && w_e_ok && (w_diffv > 23'sd0);

    assign w_wsat   = w_gap[33] ? 16'd0 :
                      ((w_gap > 34'sd65535) ? 16'hFFFF : w_gap[15:0]);

    assign w_pad    = (w_div_rem != 20'd0) ? (w_sleep - w_div_rem) : 20'd0;

    fpsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_op == fpsp_pkg::OP_DIVGO),
        .i_dividend (r_diff),
        .i_divisor  (w_sleep),
        .o_busy     (w_div_busy),
        .o_rem      (w_div_rem)
    );

    // Persistent clock state and loop control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m       <= '0;
            r_r       <= '0;
            r_last    <= '0;
            r_started <= 1'b0;
            r_count   <= '0;
            r_need    <= 1'b0;
            r_cont    <= 1'b0;
            r_stv     <= 1'b0;
        end else begin
            case (i_op)
                fpsp_pkg::OP_LOAD: begin
                    r_count <= '0;
                    if (w_reseed) begin
                        r_m       <= w_behind;
                        r_r       <= '0;
                        r_last    <= w_behind;
                        r_started <= 1'b1;
                    end
                end
                fpsp_pkg::OP_CHECK: begin
                    r_cont <= (r_count < w_limit) && w_below;
                    r_stv  <= (r_count == w_limit) && w_below;
                end
                fpsp_pkg::OP_WORK, fpsp_pkg::OP_SADD: begin
                    r_m <= w_m_sum;
                    r_r <= w_rs_fix[9:0];
                end
                fpsp_pkg::OP_PULL: begin
                    r_last <= w_last_pull;
                end
                fpsp_pkg::OP_DIFF: begin
                    r_need <= w_need;
                end
                fpsp_pkg::OP_FIN: begin
                    r_last  <= w_f;
                    r_count <= r_count + 7'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            fpsp_pkg::OP_LOAD: begin
                r_target <= i_target_ms;
                r_x      <= {1'b0, i_cfg.work_us};
            end
            fpsp_pkg::OP_SPL1: begin
                r_prod <= {22'd0, r_x} * {21'd0, fpsp_pkg::RECIP_K};
            end
            fpsp_pkg::OP_SPL2: begin
                r_sq <= w_q + {11'd0, w_corr};
                r_sr <= w_rem_fix[9:0];
            end
            fpsp_pkg::OP_WSAV: begin
                r_wq <= r_sq;
                r_wr <= r_sr;
            end
            fpsp_pkg::OP_PULL: begin
                if (r_count == 7'd0) begin
                    r_first <= w_last_pull[31:0];
                end
            end
            fpsp_pkg::OP_DIFF: begin
                r_diff <= w_diffv[19:0];
            end
            fpsp_pkg::OP_ADDX: begin
                r_x <= {1'b0, r_diff} + {1'b0, w_pad};
            end
            fpsp_pkg::OP_FIN: begin
                r_width <= w_wsat;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((i_op == fpsp_pkg::OP_EMIT) || (i_op == fpsp_pkg::OP_EMPTY)) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == fpsp_pkg::OP_EMIT) begin
            r_o_width   <= r_width;
            r_o_first   <= r_first;
            r_o_nosteps <= 1'b0;
            r_o_starved <= !r_cont && r_stv;
            r_o_last    <= !r_cont;
        end else if (i_op == fpsp_pkg::OP_EMPTY) begin
            r_o_width   <= 16'd0;
            r_o_first   <= r_last[31:0];
            r_o_nosteps <= 1'b1;
            r_o_starved <= r_stv;
            r_o_last    <= 1'b1;
        end
    end

    assign o_status.cont       = r_cont;
    assign o_status.count_zero = (r_count == 7'd0);
    assign o_status.need       = r_need;
    assign o_status.div_busy   = w_div_busy;
    assign o_status.out_free   = !r_ov || i_out_ready;

    assign o_out_valid      = r_ov;
    assign o_width_ms       = r_o_width;
    assign o_first_start_ms = r_o_first;
    assign o_no_steps       = r_o_nosteps;
    assign o_starved        = r_o_starved;
    assign o_last_of_run    = r_o_last;

endmodule

// File: rtl/fpsp_ctrl.sv
`timescale 1ns / 1ps
module fpsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fpsp_pkg::t_status i_status,
    output logic              o_in_ready,
    output fpsp_pkg::t_op     o_op
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WS1   = 4'd1;
    localparam logic [3:0] ST_WS2   = 4'd2;
    localparam logic [3:0] ST_WSAV  = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_OUT   = 4'd5;
    localparam logic [3:0] ST_WORK  = 4'd6;
    localparam logic [3:0] ST_PULL  = 4'd7;
    localparam logic [3:0] ST_DIFF  = 4'd8;
    localparam logic [3:0] ST_SLEEP = 4'd9;
    localparam logic [3:0] ST_DIVW  = 4'd10;
    localparam logic [3:0] ST_ADDX  = 4'd11;
    localparam logic [3:0] ST_SS1   = 4'd12;
    localparam logic [3:0] ST_SS2   = 4'd13;
    localparam logic [3:0] ST_SADD  = 4'd14;
    localparam logic [3:0] ST_FIN   = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_op    = fpsp_pkg::OP_NOP;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = fpsp_pkg::OP_LOAD;
                    n_state = ST_WS1;
                end
            end
            ST_WS1: begin
                o_op    = fpsp_pkg::OP_SPL1;
                n_state = ST_WS2;
            end
            ST_WS2: begin
                o_op    = fpsp_pkg::OP_SPL2;
                n_state = ST_WSAV;
            end
            ST_WSAV: begin
                o_op    = fpsp_pkg::OP_WSAV;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                o_op    = fpsp_pkg::OP_CHECK;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.count_zero && i_status.cont) begin
                    n_state = ST_WORK;
                end else if (i_status.out_free) begin
                    o_op    = i_status.count_zero ? fpsp_pkg::OP_EMPTY : fpsp_pkg::OP_EMIT;
                    n_state = (!i_status.count_zero && i_status.cont) ? ST_WORK : ST_IDLE;
                end
            end
            ST_WORK: begin
                o_op    = fpsp_pkg::OP_WORK;
                n_state = ST_PULL;
            end
            ST_PULL: begin
                o_op    = fpsp_pkg::OP_PULL;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                o_op    = fpsp_pkg::OP_DIFF;
                n_state = ST_SLEEP;
            end
            ST_SLEEP: begin
                if (i_status.need) begin
                    o_op    = fpsp_pkg::OP_DIVGO;
                    n_state = ST_DIVW;
                end else begin
                    o_op    = fpsp_pkg::OP_FIN;
                    n_state = ST_CHK;
                end
            end
            ST_DIVW: begin
                if (!i_status.div_busy) begin
                    n_state = ST_ADDX;
                end
            end
            ST_ADDX: begin
                o_op    = fpsp_pkg::OP_ADDX;
                n_state = ST_SS1;
            end
            ST_SS1: begin
                o_op    = fpsp_pkg::OP_SPL1;
                n_state = ST_SS2;
            end
            ST_SS2: begin
                o_op    = fpsp_pkg::OP_SPL2;
                n_state = ST_SADD;
            end
            ST_SADD: begin
                o_op    = fpsp_pkg::OP_SADD;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_op    = fpsp_pkg::OP_FIN;
                n_state = ST_CHK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: rtl/frame_pacing_step_planner.sv
`timescale 1ns / 1ps
// Frame pacing step planner. Each transfer on the input stream carries a target time in
// milliseconds; the block walks its virtual microsecond clock toward that target and sends
// one transfer per credited frame (its width in ms, saturated at 65535), all carrying the
// clock's ms at the start of the first frame; the final transfer of a run raises tlast and,
// if the step limit ran out short of the target, the starved flag. A target that owes no
// frames yields a single empty transfer with the no-steps flag. The clock reseeds one frame
// behind the target when it has not started or has drifted past max_drift_ms. The block
// takes one target at a time; a run begins with the input transfer and the split of the
// work time, then steps through each frame, where a 20-bit remainder unit working four
// bits per cycle lengthens a frame when the limiter has to sleep, then closes the run; the
// output side stalls the block while it holds tready low. An empty run skips the frame
// steps. A run credits up to 64 frames.
// The clock is held as whole ms plus a sub-ms remainder, so no wide division is needed.
module frame_pacing_step_planner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] target_ms, [31] zero
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] width_ms, [47:16] first_start_ms
    output logic        o_m_axis_tlast,   // last_of_run
    output logic [1:0]  o_m_axis_tuser    // [0] no_steps, [1] starved
);

    fpsp_pkg::t_cfg    r_cfg;
    fpsp_pkg::t_status w_status;
    fpsp_pkg::t_op     w_op;

    logic        w_in_ready;
    logic [15:0] w_width;
    logic [31:0] w_first;
    logic        w_nosteps;
    logic        w_starved;
    logic        w_last;

    // Configuration registers: write on enable, ignore unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ms      <= fpsp_pkg::RST_STEP_MS;
            r_cfg.frametime_ms <= fpsp_pkg::RST_FRAMETIME_MS;
            r_cfg.max_drift_ms <= fpsp_pkg::RST_MAX_DRIFT_MS;
            r_cfg.work_us      <= fpsp_pkg::RST_WORK_US;
            r_cfg.sleep_us     <= fpsp_pkg::RST_SLEEP_US;
            r_cfg.step_limit   <= fpsp_pkg::RST_STEP_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpsp_pkg::CFG_STEP_MS:      r_cfg.step_ms      <= i_cfg_wdata[9:0];
                fpsp_pkg::CFG_FRAMETIME_MS: r_cfg.frametime_ms <= i_cfg_wdata[9:0];
                fpsp_pkg::CFG_MAX_DRIFT_MS: r_cfg.max_drift_ms <= i_cfg_wdata[15:0];
                fpsp_pkg::CFG_WORK_US:      r_cfg.work_us      <= i_cfg_wdata;
                fpsp_pkg::CFG_SLEEP_US:     r_cfg.sleep_us     <= i_cfg_wdata;
                fpsp_pkg::CFG_STEP_LIMIT:   r_cfg.step_limit   <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: one target at a time, stalls on a full output register
    fpsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_op       (w_op)
    );

    // Clock state, arithmetic and the output register
    fpsp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_cfg            (r_cfg),
        .i_target_ms      (i_s_axis_tdata[30:0]),
        .i_out_ready      (i_m_axis_tready),
        .o_status         (w_status),
        .o_out_valid      (o_m_axis_tvalid),
        .o_width_ms       (w_width),
        .o_first_start_ms (w_first),
        .o_no_steps       (w_nosteps),
        .o_starved        (w_starved),
        .o_last_of_run    (w_last)
    );

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tdata  = {w_first, w_width};
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tuser  = {w_starved, w_nosteps};

    // A taken target always starts work: the port closes for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still open after a transfer");

    // An empty result is always the last one of its run and carries zero width
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tlast && (o_m_axis_tdata[15:0] == 16'd0)))
        else $error("empty result not closing its run");

    // Starved only marks the final result of a run
    a_starved_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("starved flag on an inner result");

    // The remainder unit is never left running while the block waits for a target
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_status.div_busy)
        else $error("remainder unit busy while idle");

endmodule
